### rtl/core/crc32ab_pkg.sv
// Package: shared types, constants and the byte fold function for the CRC-32 block.
package crc32ab_pkg;

  localparam int unsigned DataW      = 8;
  localparam int unsigned CrcW       = 32;
  localparam int unsigned CountW     = 3;
  localparam logic [CountW-1:0] PreloadBytes = 3'd4;
  localparam logic [CrcW-1:0]   DefaultPoly  = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0]   TopBit       = 32'h8000_0000;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             last_byte;
  } req_t;

  typedef struct packed {
    logic [CrcW-1:0] crc_value;
    logic            short_message;
  } res_t;

  function automatic logic [CrcW-1:0] fold_byte(input logic [DataW-1:0] top,
                                                input logic [CrcW-1:0]  poly);
    logic [CrcW-1:0] v;
    v = {top, {(CrcW-DataW){1'b0}}};
    for (int k = 0; k < DataW; k++) begin
      if ((v & TopBit) != '0) begin
        v = {v[CrcW-2:0], 1'b0} ^ poly;
      end else begin
        v = {v[CrcW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

### rtl/core/crc32ab_core.sv
// Module: CRC register, preload counter and per-byte update.
module crc32ab_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  crc32ab_pkg::req_t                   req_i,
  input  logic [crc32ab_pkg::CrcW-1:0]        poly_i,
  output crc32ab_pkg::res_t                   res_o
);

  logic [crc32ab_pkg::CrcW-1:0]   crc_q, crc_d, crc_next;
  logic [crc32ab_pkg::CountW-1:0] count_q, count_d, count_next;
  logic                           preload;

  assign preload = (count_q < crc32ab_pkg::PreloadBytes);

  always_comb begin
    if (preload) begin
      crc_next   = {crc_q[crc32ab_pkg::CrcW-9:0], ~req_i.data_byte};
      count_next = count_q + 3'd1;
    end else begin
      crc_next   = {crc_q[crc32ab_pkg::CrcW-9:0], req_i.data_byte}
                   ^ crc32ab_pkg::fold_byte(crc_q[crc32ab_pkg::CrcW-1 -: 8], poly_i);
      count_next = count_q;
    end
  end

  always_comb begin
    res_o.short_message = (count_next < crc32ab_pkg::PreloadBytes);
    res_o.crc_value     = res_o.short_message ? '0 : ~crc_next;
  end

  always_comb begin
    crc_d   = crc_q;
    count_d = count_q;
    if (step_i) begin
      if (req_i.last_byte) begin
        crc_d   = '0;
        count_d = '0;
      end else begin
        crc_d   = crc_next;
        count_d = count_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      count_q <= '0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
    end
  end

endmodule

### rtl/core/crc32_augmented_bytewise_top.sv
// Path: a last byte is registered in the input register, and its result in the result register.
// Throughput: one byte per cycle but for the stall below; the eight polynomial steps fold
// in combinational XOR logic. A full result register that is not taken holds a last byte
// in the input register, and that holds the input.
// Reset: asynchronous, active low; clears CRC register, byte count, valids, and loads
// the polynomial register with 0x04C11DB7.
module crc32_augmented_bytewise_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,     // polynomial
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [31:0] crc_value
  output logic        m_axis_tuser     // [0] short_message
);

  logic [crc32ab_pkg::CrcW-1:0] poly_q, poly_d;
  logic                         in_valid_q, in_valid_d;
  crc32ab_pkg::req_t            in_req_q, in_req_d;
  logic                         out_valid_q, out_valid_d;
  crc32ab_pkg::res_t            out_res_q, out_res_d;
  crc32ab_pkg::res_t            core_res;
  logic                         advance;
  logic                         in_take;

  assign advance = in_valid_q && (!in_req_q.last_byte || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take = s_axis_tvalid && s_axis_tready;

  assign poly_d = cfg_we_i ? cfg_wdata_i : poly_q;

  always_comb begin
    in_valid_d = in_valid_q;
    in_req_d   = in_req_q;
    if (in_take) begin
      in_valid_d         = 1'b1;
      in_req_d.data_byte = s_axis_tdata;
      in_req_d.last_byte = s_axis_tlast;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  crc32ab_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (in_req_q),
    .poly_i (poly_q),
    .res_o  (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance && in_req_q.last_byte) begin
      out_valid_d = 1'b1;
      out_res_d   = core_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q      <= crc32ab_pkg::DefaultPoly;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      poly_q      <= poly_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_req_q  <= in_req_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.crc_value;
  assign m_axis_tuser  = out_res_q.short_message;

endmodule

### rtl/core/crc32ab_checker.sv
// Checker: port-level assertions for the CRC-32 block, bound to the top level.
module crc32ab_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  ap_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("short message with nonzero crc");

  ap_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  ap_ready_when_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while result is taken");

endmodule

bind crc32_augmented_bytewise_top crc32ab_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### bench/tb_crc32_augmented_bytewise_top.sv
// Testbench: byte-stream CRC-32 block checked against an in-bench CRC model.
`timescale 1ns / 1ps

module tb_crc32_augmented_bytewise_top;

  localparam int DrainCycles = 4;
  localparam int StallLimit  = 2000;
  localparam int RandBytes   = 700;
  localparam int PhaseCount  = 6;

  typedef enum logic {ROW_BYTE, ROW_POLY} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic        last;
    logic        checked;
    logic [31:0] exp_crc;
    logic        exp_short;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic              in_fire = 1'b0;
  logic [31:0]       poly_now = crc32ab_pkg::DefaultPoly;
  logic [31:0]       crc_reg = '0;
  int unsigned       bytes_taken = 0;
  crc32ab_pkg::res_t crc_due[$];
  int                errors = 0;
  int                burst_left = 1;
  logic [1:0]        stall_mode = '0;
  logic [5:0]        stall_phase = '0;

  // kind, value, last, checked, expected crc_value, expected short_message
  script_row_t script[$] = '{
    '{ROW_BYTE, 32'h00, 1'b1, 1'b1, 32'h0, 1'b1},
    '{ROW_BYTE, 32'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h80, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h01, 1'b1, 1'b1, 32'h0, 1'b1},
    '{ROW_BYTE, 32'h12, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h34, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h56, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h78, 1'b1, 1'b1, 32'h1234_5678, 1'b0},
    '{ROW_BYTE, 32'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{ROW_BYTE, 32'h31, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h32, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h33, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h34, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h35, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_POLY, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'hA5, 1'b1, 1'b0, 32'h0, 1'b0},
    '{ROW_POLY, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h5A, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'hC3, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h7E, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'h81, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, 32'hFF, 1'b1, 1'b0, 32'h0, 1'b0}
  };

  crc32_augmented_bytewise_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
  end

  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == '0) begin
      stall_mode <= 2'($urandom_range(0, 3));
    end
    case (stall_mode)
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      2'd2:    m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= (stall_phase[3:0] < 4'd12);
    endcase
  end

  // Update the CRC state by one byte; return 1 when the byte closes a message.
  function automatic bit advance_crc(input logic [7:0] data, input logic last,
                                     output crc32ab_pkg::res_t res);
    logic [31:0] fold;
    int          k;
    res = '0;
    if (bytes_taken < 4) begin
      crc_reg = {crc_reg[23:0], ~data};
      bytes_taken++;
    end else begin
      fold = {crc_reg[31:24], 24'h0};
      for (k = 0; k < 8; k++) begin
        fold = fold[31] ? ({fold[30:0], 1'b0} ^ poly_now) : {fold[30:0], 1'b0};
      end
      crc_reg = {crc_reg[23:0], data} ^ fold;
    end
    if (!last) begin
      return 1'b0;
    end
    if (bytes_taken < 4) begin
      res.crc_value     = '0;
      res.short_message = 1'b1;
    end else begin
      res.crc_value     = ~crc_reg;
      res.short_message = 1'b0;
    end
    crc_reg     = '0;
    bytes_taken = 0;
    return 1'b1;
  endfunction

  task automatic push_byte(input logic [7:0] data, input logic last,
                           input bit typed, input crc32ab_pkg::res_t typed_res);
    crc32ab_pkg::res_t got;
    int                gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(negedge clk_i); while (!in_fire);
    if (advance_crc(data, last, got)) begin
      crc_due.push_back(typed ? typed_res : got);
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Hold the sender until the block has drained, then load a new polynomial.
  task automatic write_poly(input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (crc_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    poly_now = value;
  endtask

  always @(posedge clk_i) begin : check_results
    crc32ab_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (crc_due.size() == 0) begin
        $error("unexpected result: crc_value %h short_message %b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = crc_due.pop_front();
        if (m_axis_tdata !== want.crc_value) begin
          $error("crc_value: expected %h, got %h", want.crc_value, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.short_message) begin
          $error("short_message: expected %b, got %b", want.short_message, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no progress for %0d cycles", StallLimit);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    script_row_t row;
    logic [31:0] poly;
    logic [7:0]  data;
    int          sent;
    int          len;
    int          phase;
    int          b;
    sent = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_POLY) begin
        write_poly(row.value);
      end else begin
        push_byte(row.value[7:0], row.last, row.checked, {row.exp_crc, row.exp_short});
      end
    end

    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       poly = crc32ab_pkg::DefaultPoly;
        1:       poly = 32'h0;
        2:       poly = 32'hFFFF_FFFF;
        3:       poly = 32'h8000_0001;
        default: poly = $urandom;
      endcase
      write_poly(poly);
      while (sent < (phase + 1) * (RandBytes / PhaseCount)) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(1, 3);
          1:       len = $urandom_range(20, 40);
          default: len = $urandom_range(4, 10);
        endcase
        for (b = 0; b < len; b++) begin
          if ($urandom_range(0, 7) == 0) begin
            data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          end else begin
            data = 8'($urandom_range(0, 255));
          end
          push_byte(data, b == len - 1, 1'b0, '0);
          sent++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (crc_due.size() != 0) @(negedge clk_i);
    repeat (2 * DrainCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
